@@ sv/i2cm_pkg.sv @@
// Shared types and codes of the I2C master register-access engine.
package i2cm_pkg;

   localparam int AckTimeoutWidth = 16;
   localparam int RegAddrWidth    = 16;
   localparam int CsrIndexWidth   = 1;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CsrAckTimeout = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrWideRegAddr = 1'd1;

   // Operation codes.
   localparam logic [1:0] OpProbe   = 2'd0;
   localparam logic [1:0] OpRead    = 2'd1;
   localparam logic [1:0] OpWrite   = 2'd2;
   localparam logic [1:0] OpRecover = 2'd3;

   typedef enum logic [4:0] {
      PhaseIdle    = 5'd0,
      PhaseStart   = 5'd1,
      PhaseAddrW   = 5'd2,
      PhaseAck1    = 5'd3,
      PhaseRegHi   = 5'd4,
      PhaseAck2    = 5'd5,
      PhaseRegLo   = 5'd6,
      PhaseAck3    = 5'd7,
      PhaseStopMid = 5'd8,
      PhaseStart2  = 5'd9,
      PhaseAddrR   = 5'd10,
      PhaseAck4    = 5'd11,
      PhaseRead    = 5'd12,
      PhaseStop    = 5'd13,
      PhaseData    = 5'd14,
      PhaseAck5    = 5'd15,
      PhaseNack    = 5'd16,
      PhaseRstop   = 5'd17
   } phase_type;

   typedef struct packed {
      logic                    command_valid;
      logic [1:0]              operation;
      logic [6:0]              device_address;
      logic [RegAddrWidth-1:0] register_address;
      logic [7:0]              write_byte;
      logic                    sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive_enable;
      logic       busy_res;
      logic       done_res;
      logic       status;
      logic [7:0] read_byte;
   } rsp_type;

   typedef struct packed {
      logic [1:0]              operation;
      logic [6:0]              device_address;
      logic [RegAddrWidth-1:0] register_address;
      logic [7:0]              write_byte;
   } cmd_type;

   typedef struct packed {
      logic oe;
      logic sda;
      logic scl;
   } line_type;

endpackage

@@ sv/i2cm_req_if.sv @@
// Request channel interface: one bus tick per beat.
interface i2cm_req_if;
   logic               valid;
   logic               ready;
   i2cm_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/i2cm_rsp_if.sv @@
// Response channel interface: bus drive and status per beat.
interface i2cm_rsp_if;
   logic               valid;
   logic               ready;
   i2cm_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/i2c_master_register_access.sv @@
// I2C master register-access engine, one bus delay tick per request beat.
//
//   channel   dir  handshake          payload
//   req_bus   in   valid/ready        command fields and sampled SDA
//   rsp_bus   out  valid/ready        SCL/SDA drive, busy, done, status, read byte
//   csr_*     in   write enable only  ack_timeout (0), wide_register_address (1)
//
// Every request beat yields exactly one response beat in the next cycle; a new
// beat is taken every cycle unless stalled. The sequencer state and the response
// register are updated together, so the rate is set by the single next-state pass.
// Reset is synchronous: bus released (SCL low, SDA high, driven), idle.
// While a response waits for rsp_bus.ready, drop req_bus.ready and hold all
// state; a beat taken the same cycle the response leaves keeps full rate.
module i2c_master_register_access #(
   parameter int RECOVER_CLOCKS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   i2cm_req_if.sink                               req_bus,
   i2cm_rsp_if.source                             rsp_bus,
   input  logic                                   csr_write_enable,
   input  logic [i2cm_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [i2cm_pkg::AckTimeoutWidth-1:0]   csr_write_data
);

   localparam int RcW = $clog2(RECOVER_CLOCKS + 1);

   // Configuration registers.
   logic [i2cm_pkg::AckTimeoutWidth-1:0] ack_timeout_ff;
   logic                                 wide_reg_ff;

   // Sequencer state.
   i2cm_pkg::phase_type                  phase_ff, phase_in;
   logic [1:0]                           sub_ff, sub_in;
   logic [2:0]                           bit_ff, bit_in;
   logic [7:0]                           shift_ff, shift_in;
   logic [i2cm_pkg::AckTimeoutWidth-1:0] timeout_ff, timeout_in;
   i2cm_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [7:0]                           received_ff, received_in;
   i2cm_pkg::line_type                   lines_ff, lines_in;
   logic [RcW-1:0]                       recover_ff, recover_in;
   logic                                 status_ff, status_in;
   logic                                 wide_latched_ff, wide_latched_in;

   // Response register.
   logic                                 rsp_valid_ff;
   i2cm_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   // Tick results shared with the output block.
   logic                                 busy;
   logic                                 done;
   i2cm_pkg::line_type                   line_tick;

   logic                                 accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // Next state: optional command start, then one sequencer step.
   always_comb begin : next_state
      i2cm_pkg::phase_type                  phase_cur;
      i2cm_pkg::phase_type                  enter_phase;
      logic                                 enter_en;
      logic [1:0]                           sub_cur;
      logic [2:0]                           bit_cur;
      logic [i2cm_pkg::AckTimeoutWidth-1:0] timeout_cur;
      i2cm_pkg::cmd_type                    cmd_cur;
      logic                                 status_cur;
      logic [RcW-1:0]                       recover_cur;
      logic [RcW-1:0]                       recover_inc;
      logic                                 wide_cur;

      phase_cur   = phase_ff;
      sub_cur     = sub_ff;
      bit_cur     = bit_ff;
      timeout_cur = timeout_ff;
      cmd_cur     = cmd_ff;
      status_cur  = status_ff;
      recover_cur = recover_ff;
      wide_cur    = wide_latched_ff;

      // Latch a command only when idle; ignore it otherwise.
      if (phase_ff == i2cm_pkg::PhaseIdle && req_bus.data.command_valid) begin
         cmd_cur.operation        = req_bus.data.operation;
         cmd_cur.device_address   = req_bus.data.device_address;
         cmd_cur.register_address = req_bus.data.register_address;
         cmd_cur.write_byte       = req_bus.data.write_byte;
         status_cur  = 1'b0;
         recover_cur = '0;
         wide_cur    = wide_reg_ff;
         phase_cur   = (req_bus.data.operation == i2cm_pkg::OpRecover) ?
                       i2cm_pkg::PhaseNack : i2cm_pkg::PhaseStart;
         sub_cur     = 2'd0;
         bit_cur     = 3'd0;
         timeout_cur = ack_timeout_ff;
      end

      busy = (phase_cur != i2cm_pkg::PhaseIdle);

      phase_in        = phase_cur;
      sub_in          = sub_cur;
      bit_in          = bit_cur;
      timeout_in      = timeout_cur;
      shift_in        = shift_ff;
      cmd_in          = cmd_cur;
      status_in       = status_cur;
      recover_in      = recover_cur;
      wide_latched_in = wide_cur;
      received_in     = received_ff;
      lines_in        = lines_ff;
      enter_en        = 1'b0;
      enter_phase     = phase_cur;
      recover_inc     = recover_cur + RcW'(1);
      done            = 1'b0;

      if (busy) begin
         unique case (phase_cur)
            i2cm_pkg::PhaseStart,
            i2cm_pkg::PhaseStart2: begin
               if (sub_cur == 2'd0) begin
                  lines_in.sda = 1'b0;
                  lines_in.oe  = 1'b1;
                  sub_in       = 2'd1;
               end else begin
                  lines_in.scl = 1'b0;
                  enter_en     = 1'b1;
                  enter_phase  = (phase_cur == i2cm_pkg::PhaseStart) ?
                                 i2cm_pkg::PhaseAddrW : i2cm_pkg::PhaseAddrR;
               end
            end
            i2cm_pkg::PhaseAddrW,
            i2cm_pkg::PhaseRegHi,
            i2cm_pkg::PhaseRegLo,
            i2cm_pkg::PhaseAddrR,
            i2cm_pkg::PhaseData: begin
               if (sub_cur == 2'd0) begin
                  lines_in.sda = shift_ff[7];
                  lines_in.oe  = 1'b1;
                  sub_in       = 2'd1;
               end else if (sub_cur == 2'd1) begin
                  lines_in.scl = 1'b1;
                  sub_in       = 2'd2;
               end else begin
                  lines_in.scl = 1'b0;
                  shift_in     = {shift_ff[6:0], 1'b0};
                  if (bit_cur == 3'd7) begin
                     enter_en = 1'b1;
                     unique case (phase_cur)
                        i2cm_pkg::PhaseAddrW: enter_phase = i2cm_pkg::PhaseAck1;
                        i2cm_pkg::PhaseRegHi: enter_phase = i2cm_pkg::PhaseAck2;
                        i2cm_pkg::PhaseRegLo: enter_phase = i2cm_pkg::PhaseAck3;
                        i2cm_pkg::PhaseAddrR: enter_phase = i2cm_pkg::PhaseAck4;
                        default:              enter_phase = i2cm_pkg::PhaseAck5;
                     endcase
                  end else begin
                     bit_in = bit_cur + 3'd1;
                     sub_in = 2'd0;
                  end
               end
            end
            i2cm_pkg::PhaseAck1,
            i2cm_pkg::PhaseAck2,
            i2cm_pkg::PhaseAck3,
            i2cm_pkg::PhaseAck4,
            i2cm_pkg::PhaseAck5: begin
               if (sub_cur == 2'd0) begin
                  lines_in.oe = 1'b0;
                  sub_in      = 2'd1;
               end else if (sub_cur == 2'd1) begin
                  sub_in = 2'd2;
               end else if (sub_cur == 2'd2) begin
                  // Poll SDA with SCL high until ACK or the timeout runs out.
                  lines_in.scl = 1'b1;
                  if (!req_bus.data.sda_sample) begin
                     sub_in = 2'd3;
                  end else if (timeout_cur != '0) begin
                     timeout_in = timeout_cur - i2cm_pkg::AckTimeoutWidth'(1);
                  end else begin
                     status_in = 1'b1;
                     sub_in    = 2'd3;
                  end
               end else if (bit_cur == 3'd0) begin
                  lines_in.scl = 1'b0;
                  bit_in       = 3'd1;
               end else if (bit_cur == 3'd1) begin
                  lines_in.oe = 1'b1;
                  bit_in      = 3'd2;
               end else begin
                  lines_in.sda = 1'b0;
                  enter_en     = 1'b1;
                  // A missing ACK always ends with a stop.
                  if (status_cur) begin
                     enter_phase = i2cm_pkg::PhaseStop;
                  end else begin
                     unique case (phase_cur)
                        i2cm_pkg::PhaseAck1: begin
                           if (cmd_cur.operation == i2cm_pkg::OpProbe)
                              enter_phase = i2cm_pkg::PhaseStop;
                           else if (wide_cur)
                              enter_phase = i2cm_pkg::PhaseRegHi;
                           else
                              enter_phase = i2cm_pkg::PhaseRegLo;
                        end
                        i2cm_pkg::PhaseAck2: enter_phase = i2cm_pkg::PhaseRegLo;
                        i2cm_pkg::PhaseAck3: begin
                           enter_phase = (cmd_cur.operation == i2cm_pkg::OpRead) ?
                                         i2cm_pkg::PhaseStopMid : i2cm_pkg::PhaseData;
                        end
                        i2cm_pkg::PhaseAck4: enter_phase = i2cm_pkg::PhaseRead;
                        default:             enter_phase = i2cm_pkg::PhaseStop;
                     endcase
                  end
               end
            end
            i2cm_pkg::PhaseRead: begin
               if (sub_cur == 2'd0) begin
                  lines_in.sda = 1'b1;
                  lines_in.oe  = 1'b1;
                  sub_in       = 2'd1;
               end else if (sub_cur == 2'd1) begin
                  lines_in.oe  = 1'b0;
                  lines_in.scl = 1'b1;
                  shift_in     = {shift_ff[6:0], req_bus.data.sda_sample};
                  sub_in       = 2'd2;
               end else begin
                  lines_in.scl = 1'b0;
                  if (bit_cur == 3'd7) begin
                     enter_en    = 1'b1;
                     enter_phase = i2cm_pkg::PhaseStop;
                  end else begin
                     bit_in = bit_cur + 3'd1;
                     sub_in = 2'd1;
                  end
               end
            end
            i2cm_pkg::PhaseStopMid,
            i2cm_pkg::PhaseStop: begin
               if (sub_cur == 2'd0) begin
                  lines_in.scl = 1'b1;
                  lines_in.oe  = 1'b1;
                  sub_in       = 2'd1;
               end else begin
                  lines_in.sda = 1'b1;
                  if (phase_cur == i2cm_pkg::PhaseStopMid) begin
                     enter_en    = 1'b1;
                     enter_phase = i2cm_pkg::PhaseStart2;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            i2cm_pkg::PhaseNack: begin
               if (sub_cur == 2'd0) begin
                  lines_in.sda = 1'b1;
                  lines_in.oe  = 1'b0;
                  sub_in       = 2'd1;
               end else if (sub_cur == 2'd1) begin
                  lines_in.scl = 1'b1;
                  sub_in       = 2'd2;
               end else begin
                  lines_in.scl = 1'b0;
                  recover_in   = recover_inc;
                  if (recover_inc >= RcW'(RECOVER_CLOCKS)) begin
                     enter_en    = 1'b1;
                     enter_phase = i2cm_pkg::PhaseRstop;
                  end else begin
                     sub_in = 2'd0;
                  end
               end
            end
            i2cm_pkg::PhaseRstop: begin
               if (sub_cur == 2'd0) begin
                  lines_in.scl = 1'b1;
                  sub_in       = 2'd1;
               end else begin
                  lines_in.sda = 1'b1;
                  done         = 1'b1;
               end
            end
            default: begin
               phase_in = i2cm_pkg::PhaseIdle;
            end
         endcase
      end

      // Phase entry: clear counters, reload the timeout, load the next byte.
      if (enter_en) begin
         phase_in   = enter_phase;
         sub_in     = 2'd0;
         bit_in     = 3'd0;
         timeout_in = ack_timeout_ff;
         unique case (enter_phase)
            i2cm_pkg::PhaseAddrW: shift_in = {cmd_cur.device_address, 1'b0};
            i2cm_pkg::PhaseRegHi: shift_in = cmd_cur.register_address[15:8];
            i2cm_pkg::PhaseRegLo: shift_in = cmd_cur.register_address[7:0];
            i2cm_pkg::PhaseAddrR: shift_in = {cmd_cur.device_address, 1'b1};
            i2cm_pkg::PhaseData:  shift_in = cmd_cur.write_byte;
            default:              shift_in = shift_in;
         endcase
      end

      if (done && cmd_cur.operation == i2cm_pkg::OpRead && !status_in) begin
         received_in = shift_in;
      end

      // The response shows the lines before the driver is re-enabled.
      line_tick = lines_in;
      if (done) begin
         phase_in    = i2cm_pkg::PhaseIdle;
         sub_in      = 2'd0;
         bit_in      = 3'd0;
         lines_in.oe = 1'b1;
      end
   end

   // Response payload for this tick.
   always_comb begin : outputs
      rsp_data_in.scl_level        = line_tick.scl;
      rsp_data_in.sda_level        = line_tick.sda;
      rsp_data_in.sda_drive_enable = line_tick.oe;
      rsp_data_in.busy_res         = busy;
      rsp_data_in.done_res         = done;
      rsp_data_in.status           = status_in;
      rsp_data_in.read_byte        = received_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= i2cm_pkg::AckTimeoutWidth'(255);
         wide_reg_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            i2cm_pkg::CsrAckTimeout:  ack_timeout_ff <= csr_write_data;
            i2cm_pkg::CsrWideRegAddr: wide_reg_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer state: advance once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= i2cm_pkg::PhaseIdle;
         sub_ff          <= 2'd0;
         bit_ff          <= 3'd0;
         shift_ff        <= 8'd0;
         timeout_ff      <= '0;
         cmd_ff          <= '0;
         received_ff     <= 8'd0;
         lines_ff        <= '{oe: 1'b1, sda: 1'b1, scl: 1'b0};
         recover_ff      <= '0;
         status_ff       <= 1'b0;
         wide_latched_ff <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         sub_ff          <= sub_in;
         bit_ff          <= bit_in;
         shift_ff        <= shift_in;
         timeout_ff      <= timeout_in;
         cmd_ff          <= cmd_in;
         received_ff     <= received_in;
         lines_ff        <= lines_in;
         recover_ff      <= recover_in;
         status_ff       <= status_in;
         wide_latched_ff <= wide_latched_in;
      end
   end

   // Response register: load on accept, drop valid once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ sv/i2cm_checker.sv @@
// Port-level checks of the I2C master engine and their bind.
module i2cm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input i2cm_pkg::rsp_type rsp_data
);

   // Each accepted request beat produces a response beat next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted beat produced no response");

   // A stalled response blocks new requests.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // Reset empties the response register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);
